// ===== rtl/bhr_pkg.sv =====
// Shared types and constants for the bilinear height-map resampler.
// Used by bhr_store, bhr_blend, the top level and the testbench; depends on nothing else.
package bhr_pkg;

	localparam int PIX_W      = 8;
	localparam int FRAC_W     = 16;
	localparam int HEIGHT_W   = 15;
	localparam int SRC_REG_W  = 10;
	localparam int MAP_REG_W  = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int GRID_W     = 11;
	localparam int PIXC_W     = 9;

	// Division by five of a value below 2^18 as a multiply and shift.
	localparam int             DIV5_SHIFT = 19;
	localparam logic [16:0]    DIV5_MUL   = 17'd104858;

	localparam logic [SRC_REG_W-1:0] SRC_WIDTH_RST  = 10'd512;
	localparam logic [SRC_REG_W-1:0] SRC_HEIGHT_RST = 10'd512;
	localparam logic [MAP_REG_W-1:0] MAP_WIDTH_RST  = 11'd256;
	localparam logic [MAP_REG_W-1:0] MAP_HEIGHT_RST = 11'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_MAP_WIDTH  = 2'd2,
		REG_MAP_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// Operation carried down the pipeline: a pixel write or a sample.
	typedef struct packed {
		logic wr;
		logic rd;
	} op_t;

endpackage

// ===== rtl/bhr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the caller must hold the divisor stable; the block does not enforce it.
module bhr_div #(
	parameter int NW = 37,
	parameter int DW = 11,
	parameter int QW = 26
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] r_s [NW];
	logic [NW-1:0] n_s [NW];
	logic [QW-1:0] q_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [DW-1:0] r_in;
		logic [NW-1:0] n_in;
		logic [QW-1:0] q_in;
		logic [DW:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = r_s[i-1];
			assign n_in = n_s[i-1];
			assign q_in = q_s[i-1];
		end

		assign trial = {r_in, n_in[NW-1]};
		assign take  = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i] <= take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
				n_s[i] <= n_in << 1;
				q_s[i] <= {q_in[QW-2:0], take};
			end
		end
	end

	assign quo = q_s[NW-1];

endmodule

// ===== rtl/bhr_store.sv =====
// Four parity banks of source pixels; fetches the 2x2 neighbourhood in one read.
// Depends on bhr_pkg.
module bhr_store import bhr_pkg::*; #(
	parameter int MAX_SRC_WIDTH  = 512,
	parameter int MAX_SRC_HEIGHT = 512,
	localparam int XW = $clog2(MAX_SRC_WIDTH),
	localparam int YW = $clog2(MAX_SRC_HEIGHT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  op_t              req,
	input  logic [XW-1:0]    wx,
	input  logic [YW-1:0]    wy,
	input  logic [PIX_W-1:0] wval,
	input  logic [XW-1:0]    ix,
	input  logic [YW-1:0]    iy,
	input  logic [XW-1:0]    x_last,
	input  logic [YW-1:0]    y_last,
	output logic             vld,
	output logic [PIX_W-1:0] p_tl,
	output logic [PIX_W-1:0] p_tr,
	output logic [PIX_W-1:0] p_bl,
	output logic [PIX_W-1:0] p_br
);

	localparam int BANK_W = (MAX_SRC_WIDTH + 1) / 2;
	localparam int BANK_H = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int DEPTH  = BANK_W * BANK_H;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [AW-1:0] bank_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
		logic [31:0] a;
		a = (32'(y) >> 1) * 32'(BANK_W) + (32'(x) >> 1);
		return AW'(a);
	endfunction

	logic [XW-1:0]    xo;
	logic [YW-1:0]    yo;
	logic             xr;
	logic             yr;
	logic [AW-1:0]    waddr;
	logic [PIX_W-1:0] rdata_s [4];
	logic             ix0_s, iy0_s, xr_s, yr_s, vld_s;
	logic [3:0][PIX_W-1:0] rdata_all;

	// The second column is ix+1 unless ix is the last column; then the bank of
	// the other parity fetches a harmless in-range neighbour that goes unused.
	assign xr = ix != x_last;
	assign yr = iy != y_last;
	assign xo = xr ? XW'(ix + XW'(1)) : ((ix == '0) ? XW'(1) : XW'(ix - XW'(1)));
	assign yo = yr ? YW'(iy + YW'(1)) : ((iy == '0) ? YW'(1) : YW'(iy - YW'(1)));
	assign waddr = bank_addr(wx, wy);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PX = 1'(b % 2);
		localparam logic PY = 1'(b / 2);
		logic [PIX_W-1:0] mem [DEPTH];
		logic [XW-1:0]    col;
		logic [YW-1:0]    row;
		logic [AW-1:0]    raddr;

		assign col   = (ix[0] == PX) ? ix : xo;
		assign row   = (iy[0] == PY) ? iy : yo;
		assign raddr = bank_addr(col, row);

		always_ff @(posedge clk) begin
			if (en && req.wr && wx[0] == PX && wy[0] == PY) begin
				mem[waddr] <= wval;
			end
			if (en && req.rd) begin
				rdata_s[b] <= mem[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ix0_s <= ix[0];
			iy0_s <= iy[0];
			xr_s  <= xr;
			yr_s  <= yr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= req.rd;
		end
	end

	assign rdata_all = {rdata_s[3], rdata_s[2], rdata_s[1], rdata_s[0]};
	assign vld  = vld_s;
	assign p_tl = rdata_all[{iy0_s, ix0_s}];
	assign p_tr = rdata_all[{iy0_s, ix0_s ^ xr_s}];
	assign p_bl = rdata_all[{iy0_s ^ yr_s, ix0_s}];
	assign p_br = rdata_all[{iy0_s ^ yr_s, ix0_s ^ xr_s}];

endmodule

// ===== rtl/bhr_blend.sv =====
// Five-stage bilinear blend and scaling by 1/2.5 into unsigned 8.8.
// Depends on bhr_pkg.
module bhr_blend import bhr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic [PIX_W-1:0]    p_tl,
	input  logic [PIX_W-1:0]    p_tr,
	input  logic [PIX_W-1:0]    p_bl,
	input  logic [PIX_W-1:0]    p_br,
	input  logic [FRAC_W-1:0]   fx,
	input  logic [FRAC_W-1:0]   fy,
	output logic                vout,
	output logic [HEIGHT_W-1:0] height
);

	logic [4:0] v_q;

	logic signed [8:0]  dt, db;
	logic signed [25:0] mt_s1, mb_s1;
	logic [PIX_W-1:0]   ptl_s1, pbl_s1;
	logic [FRAC_W-1:0]  fy_s1, fy_s2;
	logic [23:0]        ra_s2, rb_s2, ra_s3;
	logic signed [25:0] ra_sum, rb_sum;
	logic signed [24:0] dr;
	logic signed [41:0] md_s3;
	logic signed [41:0] h;
	logic [16:0]        v_s4;
	logic [33:0]        m_s5;

	assign dt = 9'(p_tr) - 9'(p_tl);
	assign db = 9'(p_br) - 9'(p_bl);

	// Each row blend is written as p_left*2^16 + (p_right - p_left)*f.
	assign ra_sum = $signed({2'b00, ptl_s1, 16'h0000}) + mt_s1;
	assign rb_sum = $signed({2'b00, pbl_s1, 16'h0000}) + mb_s1;
	assign dr     = $signed({1'b0, rb_s2}) - $signed({1'b0, ra_s2});
	assign h      = $signed({2'b00, ra_s3, 16'h0000}) + md_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mt_s1  <= dt * $signed({1'b0, fx});
			mb_s1  <= db * $signed({1'b0, fx});
			ptl_s1 <= p_tl;
			pbl_s1 <= p_bl;
			fy_s1  <= fy;
			ra_s2  <= ra_sum[23:0];
			rb_s2  <= rb_sum[23:0];
			fy_s2  <= fy_s1;
			md_s3  <= dr * $signed({1'b0, fy_s2});
			ra_s3  <= ra_s2;
			v_s4   <= h[39:23];
			m_s5   <= 34'(v_s4) * 34'(DIV5_MUL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], vin};
		end
	end

	assign vout   = v_q[4];
	assign height = m_s5[DIV5_SHIFT +: HEIGHT_W];

endmodule

// ===== rtl/bilinear_heightmap_resampler.sv =====
// Top level of the bilinear height-map resampler.
// Depends on bhr_pkg, bhr_div, bhr_store and bhr_blend.
//
// Usage. Words enter on the s_ group: s_tuser is the command (write a source
// pixel or sample a grid point) and s_tdata carries the pixel and grid fields.
// A pixel write gives no result; a sample gives one word on the m_ group with
// the height divided by 2.5 as unsigned 8.8. The four size registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. Throughput
// is one word per cycle while s_tready is high. Most of the pipeline is the
// two pipelined dividers that form gx*src_width/(map_width+1), one quotient
// bit a stage. Writes travel the same pipeline and reach the pixel banks in
// the read stage, so reads and writes stay in order without forwarding.
// Reset clears the control state and restores the register defaults; the
// pixel banks are not cleared and must be written before they are sampled.
// When the receiver stalls, the pipeline keeps accepting words until a
// result reaches its end with the output register still full; only then
// does s_tready fall.
module bilinear_heightmap_resampler import bhr_pkg::*; #(
	parameter int MAX_SRC_WIDTH  = 512,
	parameter int MAX_SRC_HEIGHT = 512,
	parameter int MAX_MAP_SIZE   = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata, lowest bit up: pix_x[8:0], pix_y[17:9], pix_value[25:18],
	// grid_x[36:26], grid_y[47:37]
	input  logic [47:0]           s_tdata,
	// s_tuser: cmd
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata, lowest bit up: height_fixed[14:0], zero pad [15]
	output logic [15:0]           m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int XW  = $clog2(MAX_SRC_WIDTH);
	localparam int YW  = $clog2(MAX_SRC_HEIGHT);
	localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int SZW = (SWW > SHW) ? SWW : SHW;
	localparam int MW  = $clog2(MAX_MAP_SIZE + 1);
	localparam int DW  = $clog2(MAX_MAP_SIZE + 2);
	localparam int NW  = MW + SZW + FRAC_W;
	localparam int QW  = SZW + FRAC_W;
	localparam int PW  = MW + SZW;

	// Configuration registers and their clamped values.
	logic [SRC_REG_W-1:0] src_width_q, src_height_q;
	logic [MAP_REG_W-1:0] map_width_q, map_height_q;
	logic [SWW-1:0]       sw;
	logic [SHW-1:0]       sh;
	logic [MW-1:0]        mw, mh;
	logic [DW-1:0]        den_x, den_y;

	// Input field views.
	logic [PIXC_W-1:0] pix_x, pix_y;
	logic [PIX_W-1:0]  pix_value;
	logic [GRID_W-1:0] grid_x, grid_y;
	logic              accept, adv;
	op_t               op_in;

	// Front stages.
	op_t              op_s1, op_s2;
	logic [XW-1:0]    wx_s1, wx_s2;
	logic [YW-1:0]    wy_s1, wy_s2;
	logic [PIX_W-1:0] wval_s1, wval_s2;
	logic [MW-1:0]    gx_s1, gy_s1;
	logic [NW-1:0]    numx_s2, numy_s2;

	// Side data travelling alongside the dividers.
	op_t [NW-1:0]              op_p;
	logic [NW-1:0][XW-1:0]     wx_p;
	logic [NW-1:0][YW-1:0]     wy_p;
	logic [NW-1:0][PIX_W-1:0]  wval_p;

	logic [QW-1:0]     qx, qy;
	logic [FRAC_W-1:0] fx_st, fy_st;
	logic              st_vld;
	logic [PIX_W-1:0]  p_tl, p_tr, p_bl, p_br;
	logic              bl_vld;
	logic [HEIGHT_W-1:0] bl_height;

	logic                out_v_q;
	logic [HEIGHT_W-1:0] out_h_q;

	assign pix_x     = s_tdata[8:0];
	assign pix_y     = s_tdata[17:9];
	assign pix_value = s_tdata[25:18];
	assign grid_x    = s_tdata[36:26];
	assign grid_y    = s_tdata[47:37];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_REG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_REG_W-1:0];
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero counts as one and anything above the maximum counts as the maximum.
	always_comb begin
		if (src_width_q == '0)                        sw = SWW'(1);
		else if (32'(src_width_q) > MAX_SRC_WIDTH)    sw = SWW'(MAX_SRC_WIDTH);
		else                                          sw = SWW'(src_width_q);
		if (src_height_q == '0)                       sh = SHW'(1);
		else if (32'(src_height_q) > MAX_SRC_HEIGHT)  sh = SHW'(MAX_SRC_HEIGHT);
		else                                          sh = SHW'(src_height_q);
		if (map_width_q == '0)                        mw = MW'(1);
		else if (32'(map_width_q) > MAX_MAP_SIZE)     mw = MW'(MAX_MAP_SIZE);
		else                                          mw = MW'(map_width_q);
		if (map_height_q == '0)                       mh = MW'(1);
		else if (32'(map_height_q) > MAX_MAP_SIZE)    mh = MW'(MAX_MAP_SIZE);
		else                                          mh = MW'(map_height_q);
	end

	assign den_x = DW'(32'(mw) + 32'd1);
	assign den_y = DW'(32'(mh) + 32'd1);

	// The whole pipeline moves together; it halts only when a result has
	// reached the end and the output register cannot take it.
	assign adv      = !(out_v_q && !m_tready && bl_vld);
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// Out-of-range pixel writes are dropped here and never reach the banks.
	always_comb begin
		op_in    = '0;
		op_in.wr = accept && cmd_t'(s_tuser) == CMD_WRITE
			&& 32'(pix_x) < 32'(sw) && 32'(pix_y) < 32'(sh);
		op_in.rd = accept && cmd_t'(s_tuser) == CMD_SAMPLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
			op_p  <= '0;
		end else if (adv) begin
			op_s1 <= op_in;
			op_s2 <= op_s1;
			op_p  <= {op_p[NW-2:0], op_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1   <= XW'(pix_x);
			wy_s1   <= YW'(pix_y);
			wval_s1 <= pix_value;
			gx_s1   <= (32'(grid_x) > 32'(mw)) ? mw : MW'(grid_x);
			gy_s1   <= (32'(grid_y) > 32'(mh)) ? mh : MW'(grid_y);

			wx_s2   <= wx_s1;
			wy_s2   <= wy_s1;
			wval_s2 <= wval_s1;
			numx_s2 <= {PW'(gx_s1) * PW'(sw), {FRAC_W{1'b0}}};
			numy_s2 <= {PW'(gy_s1) * PW'(sh), {FRAC_W{1'b0}}};

			wx_p    <= {wx_p[NW-2:0], wx_s2};
			wy_p    <= {wy_p[NW-2:0], wy_s2};
			wval_p  <= {wval_p[NW-2:0], wval_s2};

			fx_st   <= qx[FRAC_W-1:0];
			fy_st   <= qy[FRAC_W-1:0];
		end
	end

	bhr_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
		.clk (clk),
		.en  (adv),
		.num (numx_s2),
		.den (den_x),
		.quo (qx)
	);

	bhr_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
		.clk (clk),
		.en  (adv),
		.num (numy_s2),
		.den (den_y),
		.quo (qy)
	);

	// The integer part of each position is always below the source size.
	bhr_store #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.req    (op_p[NW-1]),
		.wx     (wx_p[NW-1]),
		.wy     (wy_p[NW-1]),
		.wval   (wval_p[NW-1]),
		.ix     (qx[FRAC_W +: XW]),
		.iy     (qy[FRAC_W +: YW]),
		.x_last (XW'(sw - SWW'(1))),
		.y_last (YW'(sh - SHW'(1))),
		.vld    (st_vld),
		.p_tl   (p_tl),
		.p_tr   (p_tr),
		.p_bl   (p_bl),
		.p_br   (p_br)
	);

	bhr_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vin    (st_vld),
		.p_tl   (p_tl),
		.p_tr   (p_tr),
		.p_bl   (p_bl),
		.p_br   (p_br),
		.fx     (fx_st),
		.fy     (fy_st),
		.vout   (bl_vld),
		.height (bl_height)
	);

	// Output register: a taken word empties it, a new result refills it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && bl_vld) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && bl_vld) begin
			out_h_q <= bl_height;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_h_q};

endmodule

// ===== tb/tb_bilinear_heightmap_resampler.sv =====
// Self-checking testbench for the bilinear height-map resampler.
// Depends on bhr_pkg and the block's RTL. Carries its own copy of the pixel
// store and of the blend arithmetic and checks every result word against it.
`timescale 1ns / 100ps

module tb_bilinear_heightmap_resampler;
	import bhr_pkg::*;

	localparam int STORE_W     = 512;
	localparam int STORE_DEPTH = 512 * 512;
	// Enough cycles to drain the pipeline.
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 600000;

	// Holds the expected heights and the image as the block should see it.
	// A flag per pixel records whether it has been written, so that the
	// stimulus can fill any neighbour a sample is about to read.
	class height_scoreboard;
		bit [7:0]          pixel_mem [STORE_DEPTH];
		bit                pixel_set [STORE_DEPTH];
		logic [9:0]        src_w_reg, src_h_reg;
		logic [10:0]       map_w_reg, map_h_reg;
		logic [14:0]       height_q [$];
		int                errors;
		int                heights_checked;

		function new();
			src_w_reg = SRC_WIDTH_RST;
			src_h_reg = SRC_HEIGHT_RST;
			map_w_reg = MAP_WIDTH_RST;
			map_h_reg = MAP_HEIGHT_RST;
		endfunction

		function int clamp_size(int v, int hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function int src_w(); return clamp_size(src_w_reg, 512); endfunction
		function int src_h(); return clamp_size(src_h_reg, 512); endfunction
		function int map_w(); return clamp_size(map_w_reg, 1024); endfunction
		function int map_h(); return clamp_size(map_h_reg, 1024); endfunction

		function void set_reg(cfg_reg_t idx, logic [10:0] v);
			unique case (idx)
				REG_SRC_WIDTH: src_w_reg = v[9:0];
				REG_SRC_HEIGHT: src_h_reg = v[9:0];
				REG_MAP_WIDTH: map_w_reg = v;
				REG_MAP_HEIGHT: map_h_reg = v;
			endcase
		endfunction

		// Source position along one axis: the two neighbouring indices and
		// the 16-bit fraction between them.
		function void axis_span(input int g, input int size, input int map,
				output int i0, output int i1, output longint unsigned frac);
			longint unsigned pos;
			if (g > map) g = map;
			pos = (longint'(g) * size * 65536) / (map + 1);
			i0 = int'(pos >> 16);
			i1 = i0 + 1;
			frac = pos & 64'hFFFF;
			if (i0 >= size) i0 = size - 1;
			if (i1 >= size) i1 = size - 1;
		endfunction

		function void sample_span(input int gx, input int gy,
				output int x0, output int x1, output int y0, output int y1,
				output longint unsigned fx, output longint unsigned fy);
			axis_span(gx, src_w(), map_w(), x0, x1, fx);
			axis_span(gy, src_h(), map_h(), y0, y1, fy);
		endfunction

		function bit is_set(int x, int y);
			return pixel_set[y * STORE_W + x];
		endfunction

		function void note_word(logic cmd, logic [47:0] d);
			int x0, x1, y0, y1;
			longint unsigned fx, fy, upper, lower, h;
			if (cmd == CMD_WRITE) begin
				// Writes outside the current source size are dropped.
				if (d[8:0] < src_w() && d[17:9] < src_h()) begin
					pixel_mem[d[17:9] * STORE_W + d[8:0]] = d[25:18];
					pixel_set[d[17:9] * STORE_W + d[8:0]] = 1'b1;
				end
				return;
			end
			sample_span(d[36:26], d[47:37], x0, x1, y0, y1, fx, fy);
			upper = pixel_mem[y0 * STORE_W + x0] * (65536 - fx)
				+ pixel_mem[y0 * STORE_W + x1] * fx;
			lower = pixel_mem[y1 * STORE_W + x0] * (65536 - fx)
				+ pixel_mem[y1 * STORE_W + x1] * fx;
			h = upper * (65536 - fy) + lower * fy;
			height_q.push_back(15'(h / (64'd5 << 23)));
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_word(logic [15:0] d);
			logic [14:0] want;
			if (height_q.size() == 0) begin
				report($sformatf("height %0d with nothing expected", d[14:0]));
				return;
			end
			want = height_q.pop_front();
			heights_checked++;
			if (d[14:0] !== want)
				report($sformatf("height %0d, expected %0d", d[14:0], want));
			if (d[15] !== 1'b0)
				report("pad bit of m_tdata is not zero");
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	height_scoreboard sb = new();
	int cycles;
	int words_sent;
	int burst_left;
	int settings_run;

	bilinear_heightmap_resampler i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Every result word is checked at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// The receiver switches between long ready stretches, coin-toss
	// stalling and long stalls, so back pressure lands on every phase.
	initial begin
		int mode, span;
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 200);
			repeat (span) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Offers one word and holds it until it is taken. The sender works in
	// bursts; at the end of each one the valid drops for a random gap.
	task send_word(logic cmd, logic [47:0] d);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_word(cmd, d);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(0, 15);
		end
	endtask

	task write_pixel(int x, int y, logic [7:0] v);
		send_word(CMD_WRITE, {11'd0, 11'd0, v, 9'(y), 9'(x)});
	endtask

	// A sample never reads a pixel that has not been written: any missing
	// neighbour is given a random value first.
	task sample_point(int gx, int gy);
		int x0, x1, y0, y1;
		longint unsigned fx, fy;
		sb.sample_span(gx, gy, x0, x1, y0, y1, fx, fy);
		if (!sb.is_set(x0, y0)) write_pixel(x0, y0, 8'($urandom));
		if (!sb.is_set(x1, y0)) write_pixel(x1, y0, 8'($urandom));
		if (!sb.is_set(x0, y1)) write_pixel(x0, y1, 8'($urandom));
		if (!sb.is_set(x1, y1)) write_pixel(x1, y1, 8'($urandom));
		send_word(CMD_SAMPLE, {11'(gy), 11'(gx), 8'($urandom), 9'($urandom), 9'($urandom)});
	endtask

	// Waits until the block is idle, then writes all four size registers.
	task set_sizes(logic [10:0] sw, logic [10:0] sh, logic [10:0] mw, logic [10:0] mh);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.height_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int r = 0; r < 4; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(r);
			cfg_data  <= (r == 0) ? sw : (r == 1) ? sh : (r == 2) ? mw : mh;
			sb.set_reg(cfg_reg_t'(r), (r == 0) ? sw : (r == 1) ? sh : (r == 2) ? mw : mh);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Mostly samples across the grid and beyond it, with pixel
	// overwrites and writes that fall outside the source mixed in.
	// The phase runs until about n words, neighbour fills included, have gone.
	task random_phase(int n);
		int stop;
		stop = words_sent + n;
		while (words_sent < stop) begin
			case ($urandom_range(0, 9))
				0: write_pixel($urandom_range(0, 511), $urandom_range(0, 511),
					8'($urandom));
				1: write_pixel($urandom_range(0, sb.src_w() - 1),
					$urandom_range(0, sb.src_h() - 1), 8'($urandom));
				2: sample_point($urandom_range(0, 2047), $urandom_range(0, 2047));
				default: sample_point($urandom_range(0, sb.map_w()),
					$urandom_range(0, sb.map_h()));
			endcase
		end
	endtask

	initial begin
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset sizes: value extremes, the far corner of
		// the store, grid corners and grid points beyond the map.
		write_pixel(0, 0, 8'hFF);
		write_pixel(1, 0, 8'h00);
		write_pixel(0, 1, 8'h00);
		write_pixel(1, 1, 8'hFF);
		write_pixel(511, 511, 8'hFF);
		sample_point(0, 0);
		sample_point(1, 1);
		sample_point(256, 256);
		sample_point(2047, 2047);
		sample_point(255, 0);
		random_phase(60);

		// Smallest sizes: one pixel, writes outside it are dropped.
		set_sizes(11'd1, 11'd1, 11'd1, 11'd1);
		write_pixel(0, 0, 8'hFF);
		write_pixel(1, 0, 8'h00);
		write_pixel(0, 1, 8'h00);
		write_pixel(511, 511, 8'h00);
		sample_point(0, 0);
		sample_point(1, 1);
		sample_point(2047, 0);
		random_phase(40);

		// Zero sizes count as one.
		set_sizes(11'd0, 11'd0, 11'd0, 11'd0);
		random_phase(40);

		// Largest sizes and sizes beyond the limits.
		set_sizes(11'd512, 11'd512, 11'd1024, 11'd1024);
		sample_point(1024, 1024);
		sample_point(1023, 1);
		random_phase(100);
		set_sizes(11'd1023, 11'd1023, 11'd2047, 11'd2047);
		random_phase(100);

		// Upsampling, downsampling and lopsided shapes with random sizes.
		set_sizes(11'd3, 11'd512, 11'd1024, 11'd2);
		random_phase(80);
		for (int p = 0; p < 5; p++) begin
			set_sizes(11'($urandom_range(1, 40)), 11'($urandom_range(1, 40)),
				11'($urandom_range(1, 100)), 11'($urandom_range(1, 100)));
			random_phase(100);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.height_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words under %0d register settings; %0d heights checked.",
			words_sent, settings_run, sb.heights_checked);
		if (sb.errors == 0 && sb.height_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bhr_pkg.sv
rtl/bhr_div.sv
rtl/bhr_store.sv
rtl/bhr_blend.sv
rtl/bilinear_heightmap_resampler.sv
tb/tb_bilinear_heightmap_resampler.sv
